FILE: rtl/qau_pkg.sv
// Shared types, widths and the arctangent table for the quaternion attitude unit.
package qau_pkg;

	localparam int CORDIC_STAGES_DEF = 16;

	localparam int N2_W = 33;
	localparam int SQ_W = N2_W + 28;
	localparam int RT_W = 31;
	localparam int DN_W = 60;
	localparam int QT_W = 31;
	localparam int TW   = 36;
	localparam int CW   = 38;
	localparam int ZW   = 34;

	localparam logic signed [TW-1:0] Q30_ONE = TW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1686629713);

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [31:0] vec_north;
		logic signed [31:0] vec_east;
		logic signed [31:0] vec_down;
	} req_t;

	typedef struct packed {
		logic signed [31:0] axis_one;
		logic signed [31:0] axis_two;
		logic signed [31:0] axis_three;
		logic               bad_input;
	} rsp_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [RT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DN_W-1:0] rem;
		logic [QT_W-1:0] quo;
	} dv_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cr_t;

	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic [31:0] v;
		unique case (i)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return ZW'(signed'({1'b0, v}));
	endfunction

endpackage

FILE: rtl/qau_sqrt_cell.sv
// One bit of a restoring integer square root, registered.
module qau_sqrt_cell import qau_pkg::*; #(
	parameter int K = 0
) (
	input  logic clk,
	input  logic en,
	input  sq_t  d,
	output sq_t  q
);

	logic [SQ_W+1:0] t;
	logic            take;
	logic [RT_W-1:0] bitk;

	assign t    = ((SQ_W+2)'(d.root) << (K + 1)) + ((SQ_W+2)'(1) << (2 * K));
	assign take = {2'b00, d.rem} >= t;
	assign bitk = RT_W'(1) << K;

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem  <= take ? d.rem - t[SQ_W-1:0] : d.rem;
			q.root <= take ? (d.root | bitk) : d.root;
		end
	end

endmodule

FILE: rtl/qau_div_cell.sv
// One quotient bit of a restoring divider, registered.
module qau_div_cell import qau_pkg::*; #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RT_W-1:0] den,
	input  dv_t             d,
	output dv_t             q
);

	logic [DN_W:0]   t;
	logic            take;
	logic [QT_W-1:0] bitk;

	assign t    = (DN_W+1)'(den) << K;
	assign take = {1'b0, d.rem} >= t;
	assign bitk = QT_W'(1) << K;

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= take ? d.rem - t[DN_W-1:0] : d.rem;
			q.quo <= take ? (d.quo | bitk) : d.quo;
		end
	end

endmodule

FILE: rtl/qau_cordic_cell.sv
// One CORDIC vectoring iteration, registered.
module qau_cordic_cell import qau_pkg::*; #(
	parameter int I = 0
) (
	input  logic clk,
	input  logic en,
	input  cr_t  d,
	output cr_t  q
);

	logic signed [CW-1:0] xs, ys, dx, dy;
	logic signed [ZW-1:0] zs, ang;

	assign xs  = d.x;
	assign ys  = d.y;
	assign zs  = d.z;
	assign dx  = xs >>> I;
	assign dy  = ys >>> I;
	assign ang = atan_val(I);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ys[CW-1]) begin
				q.x <= xs + dy;
				q.y <= ys - dx;
				q.z <= zs + ang;
			end else begin
				q.x <= xs - dy;
				q.y <= ys + dx;
				q.z <= zs - ang;
			end
		end
	end

endmodule

FILE: rtl/quaternion_attitude_unit_core.sv
// Quaternion attitude unit: normalize, then Euler angles or NED-to-body rotation.
//
// req channel: one req_t word (operation, quaternion Q2.14, NED vector Q16.16)
// is taken at each clock edge with req_valid high and req_stall low.
// rsp channel: one rsp_t word per request, in request order, held while
// rsp_stall is high.
// Throughput: one word per cycle while rsp_stall does not hold the output. The
// pipeline is the norm square-root chain (31 cells), the normalizing divide chain
// (31 cells), the pitch cosine square-root chain (31 cells), the CORDIC chain
// and seven arithmetic and output registers.
// The pipeline moves as a whole: while the output word is stalled every stage
// holds and req_stall is high; the output register lets a new word in the
// cycle that the held one is taken.
// Reset clears all valid flags; no word is in flight afterward.
// A zero quaternion gives bad_input set and all axes zero.
module quaternion_attitude_unit_core import qau_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	localparam int LAT = 1 + RT_W + QT_W + 5 + RT_W + CORDIC_STAGES;

	typedef struct packed {
		logic                  req_type;
		logic                  bad;
		logic [3:0]            neg;
		logic [3:0][15:0]      mag;
		logic signed [2:0][31:0] vec;
	} pa_t;

	typedef struct packed {
		logic                    req_type;
		logic                    bad;
		logic [3:0]              neg;
		logic signed [2:0][31:0] vec;
		logic [RT_W-1:0]         den;
	} pb_t;

	typedef struct packed {
		logic                    req_type;
		logic                    bad;
		logic signed [TW-1:0]    ra_y;
		logic signed [TW-1:0]    ra_x;
		logic signed [31:0]      pit;
		logic signed [TW-1:0]    yw_y;
		logic signed [TW-1:0]    yw_x;
		logic signed [2:0][31:0] rot;
	} pg_t;

	typedef struct packed {
		logic                    req_type;
		logic                    bad;
		logic [2:0]              zero;
		logic signed [2:0][31:0] rot;
	} ph_t;

	function automatic logic signed [TW-1:0] t29(input logic signed [64:0] s);
		return TW'(s >>> 29);
	endfunction

	logic en;
	logic [LAT-1:0] vld_q;
	logic rsp_valid_q;
	rsp_t rsp_word_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], req_valid};
			rsp_valid_q <= vld_q[LAT-1];
		end
	end

	// stage 1: magnitudes and squared norm
	logic signed [15:0] qin [4];
	logic [15:0] mg [4];
	logic [31:0] sqv [4];
	logic [N2_W-1:0] n2;
	pa_t pa_s1;
	logic [N2_W-1:0] n2_s1;

	assign qin[0] = req_word.quat_w;
	assign qin[1] = req_word.quat_x;
	assign qin[2] = req_word.quat_y;
	assign qin[3] = req_word.quat_z;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			mg[l]  = qin[l][15] ? 16'(-qin[l]) : 16'(qin[l]);
			sqv[l] = mg[l] * mg[l];
		end
		n2 = N2_W'(sqv[0]) + N2_W'(sqv[1]) + N2_W'(sqv[2]) + N2_W'(sqv[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1.req_type <= req_word.req_type;
			pa_s1.bad      <= n2 == '0;
			for (int l = 0; l < 4; l++) begin
				pa_s1.neg[l] <= qin[l][15];
				pa_s1.mag[l] <= mg[l];
			end
			pa_s1.vec[0] <= req_word.vec_north;
			pa_s1.vec[1] <= req_word.vec_east;
			pa_s1.vec[2] <= req_word.vec_down;
			n2_s1        <= n2;
		end
	end

	// norm square root chain
	sq_t sa [RT_W+1];
	pa_t pa [RT_W+1];

	assign sa[0] = '{rem: {n2_s1, 28'b0}, root: '0};
	assign pa[0] = pa_s1;

	for (genvar j = 0; j < RT_W; j++) begin : g_sqa
		qau_sqrt_cell #(.K(RT_W - 1 - j)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sa[j]),
			.q   (sa[j+1])
		);
		always_ff @(posedge clk) begin
			if (en) pa[j+1] <= pa[j];
		end
	end

	// normalizing divide chain, four lanes
	dv_t dv [4][QT_W+1];
	pb_t pb [QT_W+1];

	assign pb[0] = '{req_type: pa[RT_W].req_type, bad: pa[RT_W].bad, neg: pa[RT_W].neg,
		vec: pa[RT_W].vec, den: sa[RT_W].root};

	for (genvar l = 0; l < 4; l++) begin : g_dvi
		assign dv[l][0] = '{rem: {pa[RT_W].mag[l], 44'b0}, quo: '0};
	end

	for (genvar j = 0; j < QT_W; j++) begin : g_dv
		for (genvar l = 0; l < 4; l++) begin : g_ln
			qau_div_cell #(.K(QT_W - 1 - j)) u_cell (
				.clk (clk),
				.en  (en),
				.den (pb[j].den),
				.d   (dv[l][j]),
				.q   (dv[l][j+1])
			);
		end
		always_ff @(posedge clk) begin
			if (en) pb[j+1] <= pb[j];
		end
	end

	// stage 2: signs restored
	logic signed [31:0] cu [4];
	logic signed [31:0] c_s2 [4];
	logic type_s2, bad_s2;
	logic signed [2:0][31:0] vec_s2;

	always_comb begin
		for (int l = 0; l < 4; l++) cu[l] = signed'({1'b0, dv[l][QT_W].quo});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) c_s2[l] <= pb[QT_W].neg[l] ? -cu[l] : cu[l];
			type_s2 <= pb[QT_W].req_type;
			bad_s2  <= pb[QT_W].bad;
			vec_s2  <= pb[QT_W].vec;
		end
	end

	// stage 3: component products
	logic signed [63:0] xx_s3, yy_s3, zz_s3, wx_s3, wy_s3, wz_s3, xy_s3, xz_s3, yz_s3;
	logic type_s3, bad_s3;
	logic signed [2:0][31:0] vec_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s3   <= c_s2[1] * c_s2[1];
			yy_s3   <= c_s2[2] * c_s2[2];
			zz_s3   <= c_s2[3] * c_s2[3];
			wx_s3   <= c_s2[0] * c_s2[1];
			wy_s3   <= c_s2[0] * c_s2[2];
			wz_s3   <= c_s2[0] * c_s2[3];
			xy_s3   <= c_s2[1] * c_s2[2];
			xz_s3   <= c_s2[1] * c_s2[3];
			yz_s3   <= c_s2[2] * c_s2[3];
			type_s3 <= type_s2;
			bad_s3  <= bad_s2;
			vec_s3  <= vec_s2;
		end
	end

	// stage 4: doubled terms and matrix entries
	logic signed [TW-1:0] pt;
	logic signed [TW-1:0] r_s4 [3][3];
	logic signed [TW-1:0] ra_y_s4, yw_y_s4;
	logic signed [31:0] p_s4;
	logic type_s4, bad_s4;
	logic signed [2:0][31:0] vec_s4;

	assign pt = t29(65'(wy_s3) - 65'(xz_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4[0][0] <= Q30_ONE - t29(65'(yy_s3) + 65'(zz_s3));
			r_s4[0][1] <= t29(65'(xy_s3) - 65'(wz_s3));
			r_s4[0][2] <= t29(65'(xz_s3) + 65'(wy_s3));
			r_s4[1][0] <= t29(65'(xy_s3) + 65'(wz_s3));
			r_s4[1][1] <= Q30_ONE - t29(65'(xx_s3) + 65'(zz_s3));
			r_s4[1][2] <= t29(65'(yz_s3) - 65'(wx_s3));
			r_s4[2][0] <= t29(65'(xz_s3) - 65'(wy_s3));
			r_s4[2][1] <= t29(65'(yz_s3) + 65'(wx_s3));
			r_s4[2][2] <= Q30_ONE - t29(65'(xx_s3) + 65'(yy_s3));
			ra_y_s4    <= t29(65'(wx_s3) + 65'(yz_s3));
			yw_y_s4    <= t29(65'(wz_s3) + 65'(xy_s3));
			if (pt > Q30_ONE) p_s4 <= 32'(Q30_ONE);
			else if (pt < -Q30_ONE) p_s4 <= 32'(-Q30_ONE);
			else p_s4 <= 32'(pt);
			type_s4 <= type_s3;
			bad_s4  <= bad_s3;
			vec_s4  <= vec_s3;
		end
	end

	// stage 5: rotation products and pitch sine squared
	logic signed [67:0] m_s5 [3][3];
	logic signed [63:0] psq_s5;
	logic signed [TW-1:0] ra_y_s5, ra_x_s5, yw_y_s5, yw_x_s5;
	logic signed [31:0] p_s5;
	logic type_s5, bad_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m_s5[i][j] <= r_s4[j][i] * signed'(vec_s4[j]);
			psq_s5  <= p_s4 * p_s4;
			ra_y_s5 <= ra_y_s4;
			ra_x_s5 <= r_s4[2][2];
			yw_y_s5 <= yw_y_s4;
			yw_x_s5 <= r_s4[0][0];
			p_s5    <= p_s4;
			type_s5 <= type_s4;
			bad_s5  <= bad_s4;
		end
	end

	// stage 6: rotation sums and cosine argument
	logic signed [69:0] acc_s6 [3];
	logic [SQ_W-1:0] carg_s6;
	logic signed [TW-1:0] ra_y_s6, ra_x_s6, yw_y_s6, yw_x_s6;
	logic signed [31:0] p_s6;
	logic type_s6, bad_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				acc_s6[i] <= 70'(m_s5[i][0]) + 70'(m_s5[i][1]) + 70'(m_s5[i][2]);
			carg_s6 <= (SQ_W'(1) << 60) - SQ_W'(psq_s5[60:0]);
			ra_y_s6 <= ra_y_s5;
			ra_x_s6 <= ra_x_s5;
			yw_y_s6 <= yw_y_s5;
			yw_x_s6 <= yw_x_s5;
			p_s6    <= p_s5;
			type_s6 <= type_s5;
			bad_s6  <= bad_s5;
		end
	end

	// round and saturate rotation results
	logic signed [69:0] rr [3];
	logic signed [2:0][31:0] rot;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rr[i] = (acc_s6[i] + 70'sd536870912) >>> 30;
			if (rr[i] > 70'sd2147483647) rot[i] = 32'sh7FFFFFFF;
			else if (rr[i] < -70'sd2147483648) rot[i] = 32'sh80000000;
			else rot[i] = 32'(rr[i]);
		end
	end

	// pitch cosine square root chain
	sq_t sb [RT_W+1];
	pg_t pg [RT_W+1];

	assign sb[0] = '{rem: carg_s6, root: '0};
	assign pg[0] = '{req_type: type_s6, bad: bad_s6, ra_y: ra_y_s6, ra_x: ra_x_s6,
		pit: p_s6, yw_y: yw_y_s6, yw_x: yw_x_s6, rot: rot};

	for (genvar j = 0; j < RT_W; j++) begin : g_sqb
		qau_sqrt_cell #(.K(RT_W - 1 - j)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sb[j]),
			.q   (sb[j+1])
		);
		always_ff @(posedge clk) begin
			if (en) pg[j+1] <= pg[j];
		end
	end

	// CORDIC: half-plane pre-rotation, then the iteration chain
	logic signed [CW-1:0] ay [3];
	logic signed [CW-1:0] ax [3];
	logic [2:0] zr;
	cr_t c0 [3];
	cr_t cr [3][CORDIC_STAGES+1];
	ph_t ph [CORDIC_STAGES+1];

	always_comb begin
		ay[0] = CW'(pg[RT_W].ra_y);
		ax[0] = CW'(pg[RT_W].ra_x);
		ay[1] = CW'(pg[RT_W].pit);
		ax[1] = CW'({1'b0, sb[RT_W].root});
		ay[2] = CW'(pg[RT_W].yw_y);
		ax[2] = CW'(pg[RT_W].yw_x);
		for (int l = 0; l < 3; l++) begin
			zr[l] = (ax[l] == '0) && (ay[l] == '0);
			if (ax[l][CW-1]) begin
				if (!ay[l][CW-1]) begin
					c0[l] = '{x: ay[l], y: -ax[l], z: HALF_PI};
				end else begin
					c0[l] = '{x: -ay[l], y: ax[l], z: -HALF_PI};
				end
			end else begin
				c0[l] = '{x: ax[l], y: ay[l], z: '0};
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_cri
		assign cr[l][0] = c0[l];
	end

	assign ph[0] = '{req_type: pg[RT_W].req_type, bad: pg[RT_W].bad, zero: zr,
		rot: pg[RT_W].rot};

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cr
		for (genvar l = 0; l < 3; l++) begin : g_ln
			qau_cordic_cell #(.I(j)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (cr[l][j]),
				.q   (cr[l][j+1])
			);
		end
		always_ff @(posedge clk) begin
			if (en) ph[j+1] <= ph[j];
		end
	end

	// output register
	logic signed [ZW-1:0] zf [3];
	logic signed [31:0] ang [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			zf[l]  = (cr[l][CORDIC_STAGES].z + ZW'(8192)) >>> 14;
			ang[l] = ph[CORDIC_STAGES].zero[l] ? '0 : 32'(zf[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ph[CORDIC_STAGES].bad) begin
				rsp_word_q <= '{axis_one: '0, axis_two: '0, axis_three: '0, bad_input: 1'b1};
			end else if (ph[CORDIC_STAGES].req_type) begin
				rsp_word_q <= '{axis_one: ph[CORDIC_STAGES].rot[0],
					axis_two: ph[CORDIC_STAGES].rot[1],
					axis_three: ph[CORDIC_STAGES].rot[2], bad_input: 1'b0};
			end else begin
				rsp_word_q <= '{axis_one: ang[0], axis_two: ang[1],
					axis_three: ang[2], bad_input: 1'b0};
			end
		end
	end

endmodule

FILE: rtl/qau_checker.sv
// Port-level checks for the quaternion attitude unit, bound to the top level.
module qau_checker import qau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_word,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_word
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("stalled rsp word changed or dropped");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_word))
		else $error("stalled req word changed or dropped");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("req_stall does not follow the stalled output word");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.bad_input |->
		rsp_word.axis_one == '0 && rsp_word.axis_two == '0 && rsp_word.axis_three == '0)
		else $error("bad_input word carries nonzero axes");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("rsp_valid high in reset");

endmodule

bind quaternion_attitude_unit_core qau_checker u_chk (.*);

FILE: verif/quaternion_attitude_unit_core_tb.sv
// Testbench for the quaternion attitude unit: directed table and random words against a predictor.
module quaternion_attitude_unit_core_tb;
	import qau_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = 100 + STAGES;
	localparam longint ONE30 = 64'sd1073741824;
	localparam longint HALFPI30 = 64'sd1686629713;
	localparam int N_RANDOM = 1530;
	localparam longint CYCLE_LIMIT = 400000;

	typedef enum logic {OP_ANGLES = 1'b0, OP_ROTATE = 1'b1} op_e;

	typedef struct {
		req_t word;
		bit   known;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_word;

	rsp_t attitude_q[$];
	int mismatches = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;

	quaternion_attitude_unit_core uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint atan2_q30(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALFPI30;
			end else begin
				x = -y; y = t; z = -HALFPI30;
			end
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dx = floor_shift(x, i);
			dy = floor_shift(y, i);
			if (y >= 0) begin
				x += dy; y -= dx; z += longint'(atan_val(i));
			end else begin
				x -= dy; y += dx; z -= longint'(atan_val(i));
			end
		end
		return floor_shift(z + 8192, 14);
	endfunction

	function automatic longint unit_comp(longint q, longint s);
		longint m;
		m = (q < 0) ? -q : q;
		m = longint'((unsigned'(m) << 44) / unsigned'(s));
		return (q < 0) ? -m : m;
	endfunction

	function automatic logic signed [31:0] round_sat(longint acc);
		longint r;
		r = floor_shift(acc + (64'sd1 << 29), 30);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic rsp_t predict_attitude(req_t q);
		rsp_t o;
		longint w, x, y, z, n2, s, p, cp, vn, ve, vd;
		longint r00, r01, r02, r10, r11, r12, r20, r21, r22, a, b, c;
		o = '0;
		w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
		n2 = w * w + x * x + y * y + z * z;
		if (n2 == 0) begin
			o.bad_input = 1'b1;
			return o;
		end
		s = int_sqrt(unsigned'(n2) << 28);
		w = unit_comp(w, s); x = unit_comp(x, s);
		y = unit_comp(y, s); z = unit_comp(z, s);
		if (op_e'(q.req_type) == OP_ANGLES) begin
			a = atan2_q30(floor_shift(w * x + y * z, 29), ONE30 - floor_shift(x * x + y * y, 29));
			p = floor_shift(w * y - z * x, 29);
			if (p > ONE30) p = ONE30;
			if (p < -ONE30) p = -ONE30;
			cp = int_sqrt(unsigned'(ONE30 * ONE30 - p * p));
			b = atan2_q30(p, cp);
			c = atan2_q30(floor_shift(w * z + x * y, 29), ONE30 - floor_shift(y * y + z * z, 29));
			o.axis_one = a[31:0];
			o.axis_two = b[31:0];
			o.axis_three = c[31:0];
		end else begin
			vn = q.vec_north; ve = q.vec_east; vd = q.vec_down;
			r00 = ONE30 - floor_shift(y * y + z * z, 29);
			r01 = floor_shift(x * y - w * z, 29);
			r02 = floor_shift(x * z + w * y, 29);
			r10 = floor_shift(x * y + w * z, 29);
			r11 = ONE30 - floor_shift(x * x + z * z, 29);
			r12 = floor_shift(y * z - w * x, 29);
			r20 = floor_shift(x * z - w * y, 29);
			r21 = floor_shift(y * z + w * x, 29);
			r22 = ONE30 - floor_shift(x * x + y * y, 29);
			o.axis_one = round_sat(r00 * vn + r10 * ve + r20 * vd);
			o.axis_two = round_sat(r01 * vn + r11 * ve + r21 * vd);
			o.axis_three = round_sat(r02 * vn + r12 * ve + r22 * vd);
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("t=%0t %s: got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// receiver: random stall plus an optional long hold-off
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_off && hold_left == 0)
			hold_left <= 600;
		if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (hold_left == 1) begin
				hold_left <= 0;
				hold_off <= 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (attitude_q.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				rsp_t e;
				e = attitude_q.pop_front();
				if (rsp_word.axis_one !== e.axis_one)
					report_mismatch("axis_one", rsp_word.axis_one, e.axis_one);
				if (rsp_word.axis_two !== e.axis_two)
					report_mismatch("axis_two", rsp_word.axis_two, e.axis_two);
				if (rsp_word.axis_three !== e.axis_three)
					report_mismatch("axis_three", rsp_word.axis_three, e.axis_three);
				if (rsp_word.bad_input !== e.bad_input)
					report_mismatch("bad_input", rsp_word.bad_input, e.bad_input);
			end
		end
	end

	task automatic send_word(req_t q, bit known, rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= q;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		attitude_q.push_back(known ? want : predict_attitude(q));
	endtask

	function automatic logic signed [15:0] rand_quat_comp();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_vec_comp();
		case ($urandom_range(4))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			2: return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t q;
		q.req_type = 1'($urandom_range(1));
		q.quat_w = rand_quat_comp();
		q.quat_x = rand_quat_comp();
		q.quat_y = rand_quat_comp();
		q.quat_z = rand_quat_comp();
		if ($urandom_range(19) == 0)
			{q.quat_w, q.quat_x, q.quat_y, q.quat_z} = '0;
		q.vec_north = rand_vec_comp();
		q.vec_east = rand_vec_comp();
		q.vec_down = rand_vec_comp();
		return q;
	endfunction

	stim_row_t stim_table[$];

	task automatic add_row(op_e op, int w, int x, int y, int z, int vn, int ve, int vd,
			bit known, rsp_t want);
		stim_row_t r;
		r.word = {logic'(op), 16'(w), 16'(x), 16'(y), 16'(z), 32'(vn), 32'(ve), 32'(vd)};
		r.known = known;
		r.want = want;
		stim_table.push_back(r);
	endtask

	initial begin
		rsp_t nil, bad, ident_vec;
		nil = '0;
		bad = '0;
		bad.bad_input = 1'b1;
		ident_vec = '{32'sd65536, -32'sd131072, 32'sd196608, 1'b0};
		// zero quaternion for both operations
		add_row(OP_ANGLES, 0, 0, 0, 0, 5, 6, 7, 1, bad);
		add_row(OP_ROTATE, 0, 0, 0, 0, -1, 32'h7FFFFFFF, 32'h80000000, 1, bad);
		// identity
		add_row(OP_ANGLES, 16384, 0, 0, 0, -1, -1, -1, 0, nil);
		add_row(OP_ROTATE, 16384, 0, 0, 0, 65536, -131072, 196608, 1, ident_vec);
		// extremes, gimbal lock, half turns, saturation
		add_row(OP_ANGLES, 32767, 32767, 32767, 32767, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, -32768, -32768, -32768, -32768, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 11585, 0, 11585, 0, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 11585, 0, -11585, 0, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 16384, 16384, 16384, -16384, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 0, 16384, 0, 0, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 0, 0, 0, 16384, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 0, 0, 0, -1, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, 1, 0, 0, 0, 0, 0, 0, 0, nil);
		add_row(OP_ANGLES, -32768, 0, 0, 32767, 0, 0, 0, 0, nil);
		add_row(OP_ROTATE, 32767, -32768, 32767, -32768, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 0, nil);
		add_row(OP_ROTATE, 11585, 11585, 0, 0, 32'h80000000, 32'h80000000,
			32'h80000000, 0, nil);
		add_row(OP_ROTATE, 0, 0, 0, -16384, 1, -1, 0, 0, nil);
		add_row(OP_ROTATE, 8192, -8192, 8192, 8192, 32'h7FFFFFFF, 32'h80000000, 1, 0, nil);
		add_row(OP_ROTATE, 1, 1, 1, 1, 123456, -654321, 999, 0, nil);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 52;
		foreach (stim_table[i])
			send_word(stim_table[i].word, stim_table[i].known, stim_table[i].want);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 37;
			end
			if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_off <= 1'b1;
			end
			send_word(rand_req(), 1'b0, nil);
		end
		req_valid <= 1'b0;
		while (attitude_q.size() != 0 || hold_off)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
